@@ hdl/lse_pkg.sv @@
// Shared types and constants for the LIFO stack engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package lse_pkg;

   localparam int DATA_W         = 32;
   localparam int ACTION_W       = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = 1;
   localparam int MIN_SWAP_COUNT = 2;

   // Raw action codes on the request channel
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH = 3'd0,
      ACT_DUMP = 3'd1,
      ACT_PEEK = 3'd2,
      ACT_POP  = 3'd3,
      ACT_SWAP = 3'd4
   } action_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_DATA     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_SHORT    = 3'd3,
      ST_USAGE    = 3'd4,
      ST_OVERFLOW = 3'd5
   } status_type;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_DUMP  = 3'd1,
      OP_PEEK  = 3'd2,
      OP_POP   = 3'd3,
      OP_SWAP  = 3'd4,
      OP_USAGE = 3'd5
   } op_type;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] push_value;
      logic                     arg_is_integer;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data_value;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] push_value;
   } cmd_type;

endpackage

`default_nettype wire

@@ hdl/lifo_stack_engine.sv @@
// LIFO stack engine top: front end, command queue, back end. Depends on lse_pkg.
// Push, pop and error results pass the queue register and the result register;
// peek adds a stack read, swap a read and writes of both words, and dump reads the first
// element, then streams one per cycle while results are taken. Push, pop and errors
// run 1 per cycle while the result is taken; peek, swap and dump occupy the sequencer.
// Reset (synchronous): stack empty, queue empty, no result pending.
`default_nettype none

module lifo_stack_engine #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire lse_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output lse_pkg::rsp_type     rsp_data
);
   import lse_pkg::*;

   cmd_type front_cmd, queue_cmd;
   logic    front_valid, front_ready;
   logic    queue_valid, queue_ready;

   lse_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   lse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   lse_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // nothing pending right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a dump streams without gaps once a non-final element is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=>
         (rsp_valid && rsp_data.status == ST_DATA))
      else $error("dump stream broken");

   // only data results continue a transaction, and they alone carry a value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DATA) |->
         (rsp_data.last && rsp_data.data_value == '0))
      else $error("non-data result not final or not zero");

endmodule

`default_nettype wire

@@ hdl/lse_front.sv @@
// Front end: accepts request transactions and classifies them into commands.
// Depends on lse_pkg.
`default_nettype none

module lse_front (
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire lse_pkg::req_type req_data,
   output logic                 cmd_valid,
   input  wire logic            cmd_ready,
   output lse_pkg::cmd_type     cmd
);
   import lse_pkg::*;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;

   always_comb begin
      cmd.push_value = req_data.push_value;
      case (req_data.action)
         ACT_PUSH: begin
            // argument check takes priority over the full check in the back end
            cmd.op = req_data.arg_is_integer ? OP_PUSH : OP_USAGE;
         end
         ACT_DUMP: cmd.op = OP_DUMP;
         ACT_PEEK: cmd.op = OP_PEEK;
         ACT_POP:  cmd.op = OP_POP;
         ACT_SWAP: cmd.op = OP_SWAP;
         default:  cmd.op = OP_USAGE;
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/lse_queue.sv @@
// Two-entry command queue between the front end and the execution back end.
// Depends on lse_pkg.
`default_nettype none

module lse_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire lse_pkg::cmd_type in_cmd,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output lse_pkg::cmd_type     out_cmd
);
   import lse_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              push, pop;

   assign in_ready  = fill_ff != (QPTR_W + 1)'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lse_back.sv @@
// Back end: stack memory, element count, operation sequencer and result register.
// Depends on lse_pkg.
`default_nettype none

module lse_back #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   output logic                 cmd_ready,
   input  wire lse_pkg::cmd_type cmd,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output lse_pkg::rsp_type     rsp_data
);
   import lse_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_PEEK    = 5'b00010,
      S_SWAP_RD = 5'b00100,
      S_SWAP_WR = 5'b01000,
      S_DUMP    = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [DATA_W-1:0]  stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]  rd_a_ff, rd_b_ff;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]  wr_data;
   logic               emit, out_free;
   rsp_type            emit_rsp;

   logic [CNT_W-1:0]   cnt_m1, cnt_m2;
   logic [ADDR_W-1:0]  top_addr, second_addr;
   logic               empty, full;

   assign cnt_m1      = cnt_ff - 1'b1;
   assign cnt_m2      = cnt_ff - CNT_W'(MIN_SWAP_COUNT);
   assign top_addr    = cnt_m1[ADDR_W-1:0];
   assign second_addr = cnt_m2[ADDR_W-1:0];
   assign empty       = cnt_ff == '0;
   assign full        = cnt_ff == CNT_W'(STACK_DEPTH);
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      cmd_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = top_addr;
      wr_data   = rd_b_ff;
      rd_en     = 1'b0;
      rd_addr_a = top_addr;
      rd_addr_b = second_addr;
      emit      = 1'b0;
      emit_rsp  = '{status: ST_DONE, data_value: '0, last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               case (cmd.op)
                  OP_PUSH: begin
                     emit = 1'b1;
                     if (full) begin
                        emit_rsp.status = ST_OVERFLOW;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[ADDR_W-1:0];
                        wr_data = cmd.push_value;
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     emit = 1'b1;
                     if (empty) begin
                        emit_rsp.status = ST_EMPTY;
                     end else begin
                        cnt_in = cnt_m1;
                     end
                  end
                  OP_PEEK: begin
                     if (empty) begin
                        emit            = 1'b1;
                        emit_rsp.status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_PEEK;
                     end
                  end
                  OP_SWAP: begin
                     if (cnt_ff < CNT_W'(MIN_SWAP_COUNT)) begin
                        emit            = 1'b1;
                        emit_rsp.status = ST_SHORT;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_SWAP_RD;
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        emit = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        idx_in   = top_addr;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     emit            = 1'b1;
                     emit_rsp.status = ST_USAGE;
                  end
               endcase
            end
         end
         S_PEEK: begin
            if (out_free) begin
               emit                = 1'b1;
               emit_rsp.status     = ST_DATA;
               emit_rsp.data_value = rd_a_ff;
               state_in            = S_IDLE;
            end
         end
         S_SWAP_RD: begin
            wr_en    = 1'b1;
            wr_addr  = top_addr;
            wr_data  = rd_b_ff;
            state_in = S_SWAP_WR;
         end
         S_SWAP_WR: begin
            // rewriting the same word while the result waits is harmless
            wr_en   = 1'b1;
            wr_addr = second_addr;
            wr_data = rd_a_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            // read data is held until the next read, so a stall just waits
            if (out_free) begin
               emit                = 1'b1;
               emit_rsp.status     = ST_DATA;
               emit_rsp.data_value = rd_a_ff;
               emit_rsp.last       = idx_ff == '0;
               if (idx_ff != '0) begin
                  rd_en     = 1'b1;
                  rd_addr_a = idx_ff - 1'b1;
                  idx_in    = idx_ff - 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (emit) begin
         rsp_ff <= emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= stack_mem[rd_addr_a];
         rd_b_ff <= stack_mem[rd_addr_b];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_lifo_stack_engine.sv @@
`timescale 1ns / 100ps
// Testbench for lifo_stack_engine: a directed table, then random operation mixes under
// three handshake idling patterns, scored against an in-bench stack predictor.
// Depends on lse_pkg and the lifo_stack_engine RTL.

module tb_lifo_stack_engine;
   import lse_pkg::*;

   localparam int STACK_DEPTH      = 32;
   localparam int N_DIRECTED       = 23;
   localparam int RANDOM_PER_PHASE = 28;
   localparam int TAIL_CYCLES      = 8;

   // action codes outside the defined set
   localparam logic [ACTION_W-1:0] ACT_BAD_LO  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_BAD_MID = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_BAD_HI  = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
      logic                     is_int;
      bit                       typed;
      rsp_type                  want;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int mismatch_count = 0;

   // predictor state
   logic signed [DATA_W-1:0] stack_words [STACK_DEPTH];
   int                       stack_level = 0;
   rsp_type                  pending_results [$];

   directed_row_type directed_rows [N_DIRECTED];

   lifo_stack_engine #(
      .STACK_DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic void predict_stack_op(input req_type item, output rsp_type outs[$]);
      rsp_type                  res;
      logic signed [DATA_W-1:0] held;
      outs = {};
      res  = '{ST_DONE, '0, 1'b1};
      case (item.action)
         ACT_PUSH: begin
            // usage check ranks above the full check
            if (!item.arg_is_integer) begin
               res.status = ST_USAGE;
            end else if (stack_level >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               stack_words[stack_level] = item.push_value;
               stack_level++;
            end
         end
         ACT_DUMP: begin
            // top to bottom; an empty stack leaves the lone done result below
            for (int n = stack_level - 1; n >= 0; n--) begin
               res.status     = ST_DATA;
               res.data_value = stack_words[n];
               res.last       = (n == 0);
               outs.push_back(res);
            end
         end
         ACT_PEEK: begin
            if (stack_level == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.status     = ST_DATA;
               res.data_value = stack_words[stack_level - 1];
            end
         end
         ACT_POP: begin
            if (stack_level == 0) begin
               res.status = ST_EMPTY;
            end else begin
               stack_level--;
            end
         end
         ACT_SWAP: begin
            if (stack_level < MIN_SWAP_COUNT) begin
               res.status = ST_SHORT;
            end else begin
               held                         = stack_words[stack_level - 1];
               stack_words[stack_level - 1] = stack_words[stack_level - 2];
               stack_words[stack_level - 2] = held;
            end
         end
         default: begin
            res.status = ST_USAGE;
         end
      endcase
      if (outs.size() == 0) begin
         outs.push_back(res);
      end
   endfunction

   function automatic req_type random_req(input int push_pct);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < push_pct) begin
         r.action = ACT_PUSH;
      end else if (pick < 97) begin
         r.action = ACTION_W'($urandom_range(int'(ACT_SWAP), int'(ACT_DUMP)));
      end else begin
         r.action = ACTION_W'($urandom_range(int'(ACT_BAD_HI), int'(ACT_BAD_LO)));
      end
      case ($urandom_range(7))
         0:       r.push_value = WORD_MAX;
         1:       r.push_value = WORD_MIN;
         2:       r.push_value = '0;
         3:       r.push_value = '1;
         default: r.push_value = $urandom;
      endcase
      r.arg_is_integer = ($urandom_range(99) < 92);
      return r;
   endfunction

   // valid is only lowered on idle cycles, so back-to-back transactions keep it high
   task automatic send_req(input req_type item, input bit typed, input rsp_type want);
      rsp_type outs [$];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_stack_op(item, outs);
      if (typed) begin
         pending_results.push_back(want);
      end else begin
         foreach (outs[n]) pending_results.push_back(outs[n]);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transaction, status %0d data %0d last %0b",
                        $time, rsp_data.status, rsp_data.data_value, rsp_data.last);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                           $time, want.status, want.data_value, want.last,
                           rsp_data.status, rsp_data.data_value, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      req_type item;
      int      push_pct;

      directed_rows = '{
         '{ACT_DUMP,    '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_PEEK,    '1,       1'b1, 1'b1, '{ST_EMPTY, '0,       1'b1}},
         '{ACT_POP,     '0,       1'b1, 1'b1, '{ST_EMPTY, '0,       1'b1}},
         '{ACT_SWAP,    '0,       1'b1, 1'b1, '{ST_SHORT, '0,       1'b1}},
         '{ACT_PUSH,    WORD_MAX, 1'b0, 1'b1, '{ST_USAGE, '0,       1'b1}},
         '{ACT_BAD_LO,  '0,       1'b1, 1'b1, '{ST_USAGE, '0,       1'b1}},
         '{ACT_BAD_MID, '1,       1'b0, 1'b1, '{ST_USAGE, '0,       1'b1}},
         '{ACT_BAD_HI,  WORD_MIN, 1'b1, 1'b1, '{ST_USAGE, '0,       1'b1}},
         '{ACT_PUSH,    WORD_MAX, 1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_SWAP,    '0,       1'b1, 1'b1, '{ST_SHORT, '0,       1'b1}},
         '{ACT_PEEK,    '0,       1'b1, 1'b1, '{ST_DATA,  WORD_MAX, 1'b1}},
         '{ACT_PUSH,    WORD_MIN, 1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_PUSH,    '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_PUSH,    '1,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_SWAP,    '0,       1'b1, 1'b0, '0},
         '{ACT_DUMP,    '0,       1'b1, 1'b0, '0},
         '{ACT_PEEK,    '0,       1'b1, 1'b0, '0},
         '{ACT_POP,     '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_POP,     '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_DUMP,    '0,       1'b1, 1'b0, '0},
         '{ACT_POP,     '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_POP,     '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}},
         '{ACT_DUMP,    '0,       1'b1, 1'b1, '{ST_DONE,  '0,       1'b1}}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 52;
      for (int k = 0; k < N_DIRECTED; k++) begin
         item.action         = directed_rows[k].action;
         item.push_value     = directed_rows[k].value;
         item.arg_is_integer = directed_rows[k].is_int;
         send_req(item, directed_rows[k].typed, directed_rows[k].want);
      end
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         // except in phase 1: fill to the top, push past it, push a non-integer, then dump, swap and peek
         if (phase != 1) begin
            while (stack_level < STACK_DEPTH) begin
               item                = random_req(100);
               item.arg_is_integer = 1'b1;
               send_req(item, 1'b0, '0);
            end
            send_req(item, 1'b0, '0);
            send_req(item, 1'b0, '0);
            item.arg_is_integer = 1'b0;
            send_req(item, 1'b0, '0);
            item.action = ACT_DUMP;
            send_req(item, 1'b0, '0);
            item.action = ACT_SWAP;
            send_req(item, 1'b0, '0);
            item.action = ACT_PEEK;
            send_req(item, 1'b0, '0);
         end

         push_pct = 50;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i % 12 == 0) begin
               push_pct = $urandom_range(75, 15);
            end
            send_req(random_req(push_pct), 1'b0, '0);
         end
         // hold off the sender until the engine has returned everything
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ lifo_stack_engine.f @@
hdl/lse_pkg.sv
hdl/lse_front.sv
hdl/lse_queue.sv
hdl/lse_back.sv
hdl/lifo_stack_engine.sv
tb/sv/tb_lifo_stack_engine.sv
